// ----- rtl/duplicate_filter_flood_router_defines.svh -----
// Assertion macros for the flood router RTL.
`ifndef DUPLICATE_FILTER_FLOOD_ROUTER_DEFINES_SVH
`define DUPLICATE_FILTER_FLOOD_ROUTER_DEFINES_SVH

// Checked on every rising edge while out of reset.
`define DFR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dfr assertion failed");

// Checked on every rising edge, reset included.
`define DFR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dfr assertion failed");

`endif

// ----- rtl/dfr_pkg.sv -----
// Types and constants for the duplicate filtering flood router.
package dfr_pkg;

  typedef enum logic [1:0] {
    DEC_LOCAL   = 2'd0,
    DEC_FORWARD = 2'd1,
    DEC_DROP    = 2'd2
  } decision_e;

  typedef enum logic {
    OP_ROUTE = 1'b0,
    OP_SWEEP = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_OUT
  } state_e;

  localparam logic        CFG_OUR_ADDR  = 1'b0;
  localparam logic        CFG_MAX_AGE   = 1'b1;
  localparam logic [31:0] BCAST_ADDR    = 32'hFFFF_FFFF;
  localparam logic [31:0] MAX_AGE_RESET = 32'd600;

  // Item traveling down the cell chain.
  typedef struct packed {
    logic        valid;
    op_e         op;
    logic [31:0] src;
    logic [31:0] num;
    logic [31:0] now;
    logic        hit;
  } token_t;

  // Cache entry written at the end of a route pass.
  typedef struct packed {
    logic [31:0] src;
    logic [31:0] num;
    logic [31:0] stamp;
  } entry_t;

endpackage

// ----- rtl/dfr_cell.sv -----
// One cache entry cell: match check, aging clear and token hand-off.
module dfr_cell
  import dfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  token_t      tok_i,
  output token_t      tok_o,
  input  logic [31:0] max_age_i,
  input  logic        wr_en_i,
  input  entry_t      wr_i
);

  logic [31:0] src_q, num_q, stamp_q;
  token_t      tok_q, tok_d;
  logic        used, match, aged;
  logic [31:0] age;

  assign used  = (src_q != '0);
  assign match = tok_i.valid && (tok_i.op == OP_ROUTE) && used &&
                 (src_q == tok_i.src) && (num_q == tok_i.num);

  // age saturates at zero when time runs backwards
  assign age  = (tok_i.now > stamp_q) ? (tok_i.now - stamp_q) : '0;
  assign aged = tok_i.valid && (tok_i.op == OP_SWEEP) && used && (age > max_age_i);

  always_comb begin
    tok_d     = tok_i;
    tok_d.hit = tok_i.hit | match;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q <= '0;
    end else if (wr_en_i) begin
      src_q <= wr_i.src;
    end else if (aged) begin
      src_q <= '0;
    end
  end

  // an empty entry never matches and is never aged, so these need no clear
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      num_q   <= wr_i.num;
      stamp_q <= wr_i.stamp;
    end
  end

  assign tok_o = tok_q;

endmodule

// ----- rtl/duplicate_filter_flood_router.sv -----
// A route beat walks the cell chain, one register per cell; at the exit its
// decision is registered and held in ST_OUT until the sink takes it. One item
// is in flight at a time: the item walks the chain one cell per cycle and the
// next item is taken after it leaves and, for a route, after the sink takes it.
// Reset: asynchronous, active low; cache empty, write pointer 0, address 0,
// maximum age 600. The block comes out of reset idle and ready.
`include "duplicate_filter_flood_router_defines.svh"

module duplicate_filter_flood_router
  import dfr_pkg::*;
#(
  parameter int CACHE_ENTRIES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [31:0] source_node_i,
  input  logic [31:0] destination_node_i,
  input  logic [31:0] packet_number_i,
  input  logic [2:0]  hops_left_i,
  input  logic [31:0] current_time_stamp_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  decision_o,
  output logic        duplicate_seen_o
);

  localparam int IdxW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

  state_e          state_q, state_d;
  logic [31:0]     our_addr_q, max_age_q;
  logic [IdxW-1:0] wp_q, wp_d;
  logic [31:0]     dst_q;
  logic [2:0]      hops_q;
  decision_e       dec_q, dec_d;
  logic            dup_q;
  logic            in_fire, exit_route, wr_go;
  token_t          chain [CACHE_ENTRIES+1];
  token_t          tok_exit;
  entry_t          wr_entry;
  logic [CACHE_ENTRIES-1:0] wr_sel;

  assign in_fire = in_valid_i && in_ready_o;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      our_addr_q <= '0;
      max_age_q  <= MAX_AGE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OUR_ADDR: our_addr_q <= cfg_data_i;
        CFG_MAX_AGE:  max_age_q  <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // inject the beat into the head of the chain
  always_comb begin
    chain[0].valid = in_fire;
    chain[0].op    = op_e'(operation_i);
    chain[0].src   = source_node_i;
    chain[0].num   = packet_number_i;
    chain[0].now   = current_time_stamp_i;
    chain[0].hit   = 1'b0;
  end

  assign tok_exit   = chain[CACHE_ENTRIES];
  assign exit_route = tok_exit.valid && (tok_exit.op == OP_ROUTE);
  assign wr_go      = exit_route && !tok_exit.hit;

  assign wr_entry.src   = tok_exit.src;
  assign wr_entry.num   = tok_exit.num;
  assign wr_entry.stamp = tok_exit.now;

  for (genvar k = 0; k < CACHE_ENTRIES; k++) begin : g_cell
    assign wr_sel[k] = wr_go && (wp_q == IdxW'(k));

    dfr_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .tok_i     (chain[k]),
      .tok_o     (chain[k+1]),
      .max_age_i (max_age_q),
      .wr_en_i   (wr_sel[k]),
      .wr_i      (wr_entry)
    );
  end

  // ring write pointer
  always_comb begin
    wp_d = wp_q;
    if (wr_go) begin
      wp_d = (wp_q == IdxW'(CACHE_ENTRIES - 1)) ? '0 : wp_q + 1'b1;
    end
  end

  // broadcast is tested before our own address
  always_comb begin
    priority if (dst_q == BCAST_ADDR) begin
      dec_d = (hops_q != '0) ? DEC_FORWARD : DEC_LOCAL;
    end else if (dst_q == our_addr_q) begin
      dec_d = DEC_LOCAL;
    end else begin
      dec_d = (hops_q != '0) ? DEC_FORWARD : DEC_DROP;
    end
    if (tok_exit.hit) begin
      dec_d = DEC_DROP;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_BUSY;
      ST_BUSY: begin
        if (tok_exit.valid) state_d = (tok_exit.op == OP_ROUTE) ? ST_OUT : ST_IDLE;
      end
      ST_OUT:  if (out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready_o  = 1'b1;
      ST_OUT:  out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wp_q    <= '0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      dst_q  <= destination_node_i;
      hops_q <= hops_left_i;
    end
    if (exit_route) begin
      dec_q <= dec_d;
      dup_q <= tok_exit.hit;
    end
  end

  assign decision_o       = dec_q;
  assign duplicate_seen_o = dup_q;

  `DFR_ASSERT(a_one_write, clk_i, rst_ni, $onehot0(wr_sel))
  `DFR_ASSERT(a_exit_busy, clk_i, rst_ni, tok_exit.valid |-> (state_q == ST_BUSY))
  `DFR_ASSERT(a_accept_closes, clk_i, rst_ni, in_fire |=> !in_ready_o)
  `DFR_ASSERT(a_dup_drop, clk_i, rst_ni,
              (out_valid_o && duplicate_seen_o) |-> (decision_o == DEC_DROP))
  `DFR_ASSERT_ALWAYS(a_no_overlap, clk_i, !(in_ready_o && out_valid_o))

endmodule
